// ----- rtl/yuv420_crop_rotate_mapper_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros used by the crop/rotate mapper RTL.
// ----------------------------------------------------------------------------
`ifndef YUV420_CROP_ROTATE_MAPPER_ASSERT_SVH
`define YUV420_CROP_ROTATE_MAPPER_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define YCRM_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define YCRM_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/ycrm_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ycrm_pkg
// Types, codes and constants of the YUV 4:2:0 crop/rotate address mapper.
// ----------------------------------------------------------------------------
package ycrm_pkg;

    // Field widths.
    localparam int DIM_W     = 13;
    localparam int ROW_W     = 12;
    localparam int PIX_W     = 8;
    localparam int PLANE_W   = 2;
    localparam int MODE_W    = 2;
    localparam int OFF_W     = 24;
    localparam int PROD_W    = 2 * DIM_W;
    localparam int CFG_IDX_W = 3;

    // Default saturation limit for source sizes.
    localparam int MAX_DIM_DEF = 4096;

    // Register values after reset.
    localparam logic [DIM_W-1:0]  RST_SRC_WIDTH   = 13'd640;
    localparam logic [DIM_W-1:0]  RST_SRC_HEIGHT  = 13'd480;
    localparam logic [DIM_W-1:0]  RST_CROP_WIDTH  = 13'd640;
    localparam logic [DIM_W-1:0]  RST_CROP_HEIGHT = 13'd480;

    // Register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SRC_WIDTH   = 3'd0,
        CFG_SRC_HEIGHT  = 3'd1,
        CFG_CROP_WIDTH  = 3'd2,
        CFG_CROP_HEIGHT = 3'd3,
        CFG_XFORM_MODE  = 3'd4
    } t_cfg_idx;

    // Transform modes.
    typedef enum logic [MODE_W-1:0] {
        MODE_CROP      = 2'd0,
        MODE_ROT90     = 2'd1,
        MODE_ROT270_MIR = 2'd2,
        MODE_NONE      = 2'd3
    } t_mode;

    // Source plane codes (luma, V, U order).
    localparam logic [PLANE_W-1:0] SRC_PLANE_Y   = 2'd0;
    localparam logic [PLANE_W-1:0] SRC_PLANE_V   = 2'd1;
    localparam logic [PLANE_W-1:0] SRC_PLANE_U   = 2'd2;
    localparam logic [PLANE_W-1:0] SRC_PLANE_BAD = 2'd3;

    // Destination plane codes (I420 order).
    localparam logic [PLANE_W-1:0] DST_PLANE_Y   = 2'd0;
    localparam logic [PLANE_W-1:0] DST_PLANE_U   = 2'd1;
    localparam logic [PLANE_W-1:0] DST_PLANE_V   = 2'd2;
    localparam logic [PLANE_W-1:0] DST_PLANE_BAD = 2'd3;

    // Window geometry of one plane.
    typedef struct packed {
        logic [DIM_W-1:0] w;
        logic [DIM_W-1:0] h;
        logic [DIM_W-1:0] cw;
        logic [DIM_W-1:0] ch;
        logic [DIM_W-1:0] ys;
        logic [DIM_W-1:0] xs;
    } t_dims;

    // Geometry of both plane kinds plus the mode.
    typedef struct packed {
        t_dims luma;
        t_dims chroma;
        t_mode mode;
    } t_geom;

    // One source pixel request.
    typedef struct packed {
        logic [PLANE_W-1:0] plane;
        logic [ROW_W-1:0]   row;
        logic [ROW_W-1:0]   col;
        logic [PIX_W-1:0]   pix;
    } t_pixel;

    // Multiply-add operands: offset = x * y + z.
    typedef struct packed {
        logic [PLANE_W-1:0] plane;
        logic [DIM_W-1:0]   x;
        logic [DIM_W-1:0]   y;
        logic [DIM_W-1:0]   z;
        logic [PIX_W-1:0]   pix;
    } t_operands;

endpackage

// ----- rtl/ycrm_cfg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ycrm_cfg
// Configuration registers and the registered window geometry derived from them.
// ----------------------------------------------------------------------------
module ycrm_cfg #(
    parameter int MAX_DIM = ycrm_pkg::MAX_DIM_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [ycrm_pkg::CFG_IDX_W-1:0]   i_cfg_addr,
    input  logic [ycrm_pkg::DIM_W-1:0]       i_cfg_wdata,
    output ycrm_pkg::t_geom                  o_geom
);

    localparam logic [ycrm_pkg::DIM_W:0] LIMIT = (ycrm_pkg::DIM_W + 1)'(MAX_DIM);

    logic [ycrm_pkg::DIM_W-1:0] r_src_width;
    logic [ycrm_pkg::DIM_W-1:0] r_src_height;
    logic [ycrm_pkg::DIM_W-1:0] r_crop_width;
    logic [ycrm_pkg::DIM_W-1:0] r_crop_height;
    ycrm_pkg::t_mode            r_mode;
    ycrm_pkg::t_geom            r_geom;
    ycrm_pkg::t_geom            n_geom;

    // Clamp a value to a limit; the limit is only taken when it is below the value.
    function automatic logic [ycrm_pkg::DIM_W-1:0] f_sat(
        input logic [ycrm_pkg::DIM_W-1:0] v,
        input logic [ycrm_pkg::DIM_W:0]   lim
    );
        return ({1'b0, v} > lim) ? lim[ycrm_pkg::DIM_W-1:0] : v;
    endfunction

    // Luma window from the raw sizes.
    function automatic ycrm_pkg::t_dims f_luma(
        input logic [ycrm_pkg::DIM_W-1:0] sw,
        input logic [ycrm_pkg::DIM_W-1:0] sh,
        input logic [ycrm_pkg::DIM_W-1:0] cw,
        input logic [ycrm_pkg::DIM_W-1:0] ch
    );
        ycrm_pkg::t_dims d;
        d.w  = f_sat(sw, LIMIT);
        d.h  = f_sat(sh, LIMIT);
        d.cw = f_sat(cw, {1'b0, d.w});
        d.ch = f_sat(ch, {1'b0, d.h});
        d.ys = d.h - d.ch;
        d.xs = d.w - d.cw;
        return d;
    endfunction

    // Chroma planes use every luma figure halved.
    function automatic ycrm_pkg::t_dims f_half(input ycrm_pkg::t_dims d);
        ycrm_pkg::t_dims q;
        q.w  = d.w  >> 1;
        q.h  = d.h  >> 1;
        q.cw = d.cw >> 1;
        q.ch = d.ch >> 1;
        q.ys = d.ys >> 1;
        q.xs = d.xs >> 1;
        return q;
    endfunction

    // Register writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_width   <= ycrm_pkg::RST_SRC_WIDTH;
            r_src_height  <= ycrm_pkg::RST_SRC_HEIGHT;
            r_crop_width  <= ycrm_pkg::RST_CROP_WIDTH;
            r_crop_height <= ycrm_pkg::RST_CROP_HEIGHT;
            r_mode        <= ycrm_pkg::MODE_CROP;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                ycrm_pkg::CFG_SRC_WIDTH:   r_src_width   <= i_cfg_wdata;
                ycrm_pkg::CFG_SRC_HEIGHT:  r_src_height  <= i_cfg_wdata;
                ycrm_pkg::CFG_CROP_WIDTH:  r_crop_width  <= i_cfg_wdata;
                ycrm_pkg::CFG_CROP_HEIGHT: r_crop_height <= i_cfg_wdata;
                ycrm_pkg::CFG_XFORM_MODE:
                    r_mode <= ycrm_pkg::t_mode'(i_cfg_wdata[ycrm_pkg::MODE_W-1:0]);
                default: ;
            endcase
        end
    end

    // Derived geometry, registered once more behind the configuration registers.
    always_comb begin
        n_geom.luma   = f_luma(r_src_width, r_src_height, r_crop_width, r_crop_height);
        n_geom.chroma = f_half(n_geom.luma);
        n_geom.mode   = r_mode;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_geom.luma   <= f_luma(ycrm_pkg::RST_SRC_WIDTH, ycrm_pkg::RST_SRC_HEIGHT,
                                    ycrm_pkg::RST_CROP_WIDTH, ycrm_pkg::RST_CROP_HEIGHT);
            r_geom.chroma <= f_half(f_luma(ycrm_pkg::RST_SRC_WIDTH,
                                           ycrm_pkg::RST_SRC_HEIGHT,
                                           ycrm_pkg::RST_CROP_WIDTH,
                                           ycrm_pkg::RST_CROP_HEIGHT));
            r_geom.mode   <= ycrm_pkg::MODE_CROP;
        end else begin
            r_geom <= n_geom;
        end
    end

    assign o_geom = r_geom;

endmodule

// ----- rtl/ycrm_window.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ycrm_window
// Window test and operand selection stage: drops pixels outside the crop window
// and forms the multiply-add operands of the destination offset.
// ----------------------------------------------------------------------------
module ycrm_window (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  ycrm_pkg::t_geom      i_geom,
    input  logic                 i_valid,
    input  ycrm_pkg::t_pixel     i_pixel,
    output logic                 o_ready,
    output logic                 o_valid,
    output ycrm_pkg::t_operands  o_ops,
    input  logic                 i_ready
);

    logic                       r_valid;
    ycrm_pkg::t_operands        r_ops;
    ycrm_pkg::t_operands        n_ops;
    logic                       n_keep;
    ycrm_pkg::t_dims            w_dims;
    logic [ycrm_pkg::DIM_W-1:0] w_row;
    logic [ycrm_pkg::DIM_W-1:0] w_col;
    logic [ycrm_pkg::DIM_W-1:0] w_r;
    logic [ycrm_pkg::DIM_W-1:0] w_c;

    // Stage moves when empty or when the next stage takes its request.
    assign o_ready = !r_valid || i_ready;

    // Window test and operands.
    always_comb begin
        w_dims = (i_pixel.plane == ycrm_pkg::SRC_PLANE_Y) ? i_geom.luma : i_geom.chroma;
        w_row  = {1'b0, i_pixel.row};
        w_col  = {1'b0, i_pixel.col};
        w_r    = w_row - w_dims.ys;
        w_c    = w_col - w_dims.xs;
        n_keep = (i_pixel.plane != ycrm_pkg::SRC_PLANE_BAD)
                 && (w_row < w_dims.h) && (w_col < w_dims.w);
        n_ops.x = '0;
        n_ops.y = '0;
        n_ops.z = '0;
        unique case (i_geom.mode)
            ycrm_pkg::MODE_CROP: begin
                n_keep  = n_keep && (w_row >= w_dims.ys) && (w_r < w_dims.ch)
                          && (w_col < w_dims.cw);
                n_ops.x = w_r;
                n_ops.y = w_dims.cw;
                n_ops.z = w_col;
            end
            ycrm_pkg::MODE_ROT90: begin
                n_keep  = n_keep && (w_row >= w_dims.ys) && (w_r < w_dims.ch)
                          && (w_col < w_dims.cw);
                n_ops.x = w_col;
                n_ops.y = w_dims.ch;
                n_ops.z = w_dims.ch - 1'b1 - w_r;
            end
            ycrm_pkg::MODE_ROT270_MIR: begin
                n_keep  = n_keep && (w_row < w_dims.ch) && (w_col >= w_dims.xs)
                          && (w_c < w_dims.cw);
                n_ops.x = w_dims.cw - 1'b1 - w_c;
                n_ops.y = w_dims.ch;
                n_ops.z = w_dims.ch - 1'b1 - w_row;
            end
            ycrm_pkg::MODE_NONE: begin
                n_keep = 1'b0;
            end
        endcase
        // Chroma planes swap from V, U to U, V order.
        unique case (i_pixel.plane)
            ycrm_pkg::SRC_PLANE_Y: n_ops.plane = ycrm_pkg::DST_PLANE_Y;
            ycrm_pkg::SRC_PLANE_V: n_ops.plane = ycrm_pkg::DST_PLANE_V;
            ycrm_pkg::SRC_PLANE_U: n_ops.plane = ycrm_pkg::DST_PLANE_U;
            default:               n_ops.plane = ycrm_pkg::DST_PLANE_BAD;
        endcase
        n_ops.pix = i_pixel.pix;
    end

    // Stage register; dropped pixels leave a bubble.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid && n_keep;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready) begin
            r_ops <= n_ops;
        end
    end

    assign o_valid = r_valid;
    assign o_ops   = r_ops;

endmodule

// ----- rtl/ycrm_madd.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ycrm_madd
// Two-stage multiply-add: a product stage and an add stage that is also the
// output register of the block.
// ----------------------------------------------------------------------------
`include "yuv420_crop_rotate_mapper_assert.svh"

module ycrm_madd (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    input  ycrm_pkg::t_operands           i_ops,
    output logic                          o_ready,
    output logic                          o_valid,
    output logic [ycrm_pkg::PLANE_W-1:0]  o_dst_plane,
    output logic [ycrm_pkg::OFF_W-1:0]    o_dst_offset,
    output logic [ycrm_pkg::PIX_W-1:0]    o_pixel,
    input  logic                          i_ready
);

    logic                          r_v3;
    logic [ycrm_pkg::PROD_W-1:0]   r_prod;
    logic [ycrm_pkg::DIM_W-1:0]    r_z;
    logic [ycrm_pkg::PLANE_W-1:0]  r_plane3;
    logic [ycrm_pkg::PIX_W-1:0]    r_pix3;
    logic                          r_v4;
    logic [ycrm_pkg::OFF_W-1:0]    r_off;
    logic [ycrm_pkg::PLANE_W-1:0]  r_plane4;
    logic [ycrm_pkg::PIX_W-1:0]    r_pix4;
    logic                          w_ready4;
    logic [ycrm_pkg::PROD_W:0]     w_sum;

    // Ready chain back from the output register.
    assign w_ready4 = !r_v4 || i_ready;
    assign o_ready  = !r_v3 || w_ready4;

    // Product stage.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
        end else if (o_ready) begin
            r_v3 <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready) begin
            r_prod   <= i_ops.x * i_ops.y;
            r_z      <= i_ops.z;
            r_plane3 <= i_ops.plane;
            r_pix3   <= i_ops.pix;
        end
    end

    // Add stage; the offset wraps to its field width.
    assign w_sum = {1'b0, r_prod} + (ycrm_pkg::PROD_W + 1)'(r_z);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v4 <= 1'b0;
        end else if (w_ready4) begin
            r_v4 <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ready4) begin
            r_off    <= w_sum[ycrm_pkg::OFF_W-1:0];
            r_plane4 <= r_plane3;
            r_pix4   <= r_pix3;
        end
    end

    assign o_valid      = r_v4;
    assign o_dst_plane  = r_plane4;
    assign o_dst_offset = r_off;
    assign o_pixel      = r_pix4;

    // A product moves on to the output register when that register is free.
    `YCRM_ASSERT_NXT(a_prod_advances, i_clk, i_rst_n, r_v3 && w_ready4, r_v4, "product request lost")
    // A stalled product stage keeps its request unchanged.
    `YCRM_ASSERT_NXT(a_prod_holds, i_clk, i_rst_n, r_v3 && !w_ready4, r_v3 && $stable(r_prod) && $stable(r_z), "stalled product changed")
    // Only pixels with a real plane reach the output.
    `YCRM_ASSERT_IMP(a_plane_ok, i_clk, i_rst_n, r_v4, r_plane4 != ycrm_pkg::DST_PLANE_BAD, "invalid destination plane")

endmodule

// ----- rtl/yuv420_crop_rotate_mapper.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// yuv420_crop_rotate_mapper
// Maps source pixels of a planar YUV 4:2:0 frame to plane and offset in a
// cropped, optionally rotated and mirrored I420 frame.
// ----------------------------------------------------------------------------
// Usage:
//   The slave stream carries one source pixel per request: tuser is the source
//   plane (luma, V, U), tdata holds row, column and sample. The master stream
//   carries one request per pixel inside the crop window: tuser is the I420
//   destination plane, tdata holds the plane offset and the unchanged sample.
//   Pixels outside the window, plane code 3 and mode 3 produce no request.
//   The user must write registers through the plain write port only while the
//   stream is idle; the block itself does not enforce it. The pipeline has four
//   register stages (input, window test, multiply, add), in that order.
//   Throughput is one pixel per clock while the receiver takes every request.
//   Derived window geometry is registered and follows a register write in the
//   cycle after. Reset clears all stage valid bits and loads the default frame
//   geometry (640x480, crop only); tready is low while reset is held.
//   When the receiver stalls, the stages fill up, bubbles from dropped pixels
//   are squeezed out, and tready drops only once every stage is occupied.
// ----------------------------------------------------------------------------
module yuv420_crop_rotate_mapper #(
    parameter int MAX_DIM = ycrm_pkg::MAX_DIM_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // Configuration write port.
    input  logic                            i_cfg_we,
    input  logic [ycrm_pkg::CFG_IDX_W-1:0]  i_cfg_addr,
    input  logic [ycrm_pkg::DIM_W-1:0]      i_cfg_wdata,
    // Source pixel stream.
    input  logic                            i_s_axis_tvalid,
    output logic                            o_s_axis_tready,
    input  logic [31:0]                     i_s_axis_tdata,  // src_row, src_col, pixel_in
    input  logic [ycrm_pkg::PLANE_W-1:0]    i_s_axis_tuser,  // src_plane
    // Destination address stream.
    output logic                            o_m_axis_tvalid,
    input  logic                            i_m_axis_tready,
    output logic [31:0]                     o_m_axis_tdata,  // dst_offset, pixel_out
    output logic [ycrm_pkg::PLANE_W-1:0]    o_m_axis_tuser   // dst_plane
);

    ycrm_pkg::t_geom             w_geom;
    logic                        r_v1;
    ycrm_pkg::t_pixel            r_pixel1;
    ycrm_pkg::t_pixel            w_pixel_in;
    logic                        w_win_ready;
    logic                        w_win_valid;
    ycrm_pkg::t_operands         w_ops;
    logic                        w_madd_ready;
    logic [ycrm_pkg::OFF_W-1:0]  w_offset;
    logic [ycrm_pkg::PIX_W-1:0]  w_pixel_out;
    logic                        w_ready1;

    // Configuration and derived geometry.
    ycrm_cfg #(
        .MAX_DIM (MAX_DIM)
    ) u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .o_geom      (w_geom)
    );

    // Unpack the slave request.
    always_comb begin
        w_pixel_in.plane = i_s_axis_tuser;
        w_pixel_in.row   = i_s_axis_tdata[ycrm_pkg::ROW_W-1:0];
        w_pixel_in.col   = i_s_axis_tdata[2*ycrm_pkg::ROW_W-1:ycrm_pkg::ROW_W];
        w_pixel_in.pix   = i_s_axis_tdata[31:2*ycrm_pkg::ROW_W];
    end

    // Input register stage.
    assign w_ready1        = !r_v1 || w_win_ready;
    assign o_s_axis_tready = i_rst_n && w_ready1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (w_ready1) begin
            r_v1 <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ready1) begin
            r_pixel1 <= w_pixel_in;
        end
    end

    // Window test stage.
    ycrm_window u_window (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_geom  (w_geom),
        .i_valid (r_v1),
        .i_pixel (r_pixel1),
        .o_ready (w_win_ready),
        .o_valid (w_win_valid),
        .o_ops   (w_ops),
        .i_ready (w_madd_ready)
    );

    // Multiply and add stages.
    ycrm_madd u_madd (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (w_win_valid),
        .i_ops        (w_ops),
        .o_ready      (w_madd_ready),
        .o_valid      (o_m_axis_tvalid),
        .o_dst_plane  (o_m_axis_tuser),
        .o_dst_offset (w_offset),
        .o_pixel      (w_pixel_out),
        .i_ready      (i_m_axis_tready)
    );

    assign o_m_axis_tdata = {w_pixel_out, w_offset};

endmodule

// ----- dv/tb_yuv420_crop_rotate_mapper.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_yuv420_crop_rotate_mapper
// Self-checking bench for the YUV 4:2:0 crop/rotate address mapper. A short
// table of pixels walks the frame corners, every transform mode, the chroma
// plane swap and the drop cases. Random phases then reprogram the frame
// geometry and stream pixels with idle gaps on both sides. Every destination
// request is checked against a typed-in value or a bench copy of the mapping.
// ----------------------------------------------------------------------------
module tb_yuv420_crop_rotate_mapper;

    localparam int          CLK_PERIOD = 20;
    localparam int          RST_CYCLES = 9;
    localparam int          DRAIN_TAIL = 8;
    localparam int          STALL_LIMIT = 2000;
    localparam int          NUM_PHASES = 10;
    localparam int          PHASE_PIXELS = 195;
    localparam int          EXP_DEPTH = 16;
    localparam int          EXP_IDX_W = 4;
    localparam int unsigned DIM_CAP = ycrm_pkg::MAX_DIM_DEF;

    // Short names for the plane codes used in the directed table.
    localparam logic [ycrm_pkg::PLANE_W-1:0] PY   = ycrm_pkg::SRC_PLANE_Y;
    localparam logic [ycrm_pkg::PLANE_W-1:0] PV   = ycrm_pkg::SRC_PLANE_V;
    localparam logic [ycrm_pkg::PLANE_W-1:0] PU   = ycrm_pkg::SRC_PLANE_U;
    localparam logic [ycrm_pkg::PLANE_W-1:0] PBAD = ycrm_pkg::SRC_PLANE_BAD;
    localparam logic [ycrm_pkg::PLANE_W-1:0] DY   = ycrm_pkg::DST_PLANE_Y;
    localparam logic [ycrm_pkg::PLANE_W-1:0] DU   = ycrm_pkg::DST_PLANE_U;
    localparam logic [ycrm_pkg::PLANE_W-1:0] DV   = ycrm_pkg::DST_PLANE_V;

    // One row of the directed table: a register write or a pixel, with an
    // optional typed-in expectation.
    typedef struct packed {
        logic                         is_cfg;
        ycrm_pkg::t_cfg_idx           idx;
        logic [ycrm_pkg::DIM_W-1:0]   val;
        logic [ycrm_pkg::PLANE_W-1:0] plane;
        logic [ycrm_pkg::ROW_W-1:0]   row;
        logic [ycrm_pkg::ROW_W-1:0]   col;
        logic [ycrm_pkg::PIX_W-1:0]   pix;
        logic                         typed;
        logic                         hit;
        logic [ycrm_pkg::PLANE_W-1:0] dplane;
        logic [ycrm_pkg::OFF_W-1:0]   off;
    } t_vec;

    // One expected destination request.
    typedef struct packed {
        logic [ycrm_pkg::PLANE_W-1:0] plane;
        logic [ycrm_pkg::OFF_W-1:0]   off;
        logic [ycrm_pkg::PIX_W-1:0]   pix;
    } t_dst_addr;

    logic                           i_clk = 1'b0;
    logic                           i_rst_n = 1'b0;
    logic                           i_cfg_we = 1'b0;
    logic [ycrm_pkg::CFG_IDX_W-1:0] i_cfg_addr = '0;
    logic [ycrm_pkg::DIM_W-1:0]     i_cfg_wdata = '0;
    logic                           i_s_axis_tvalid = 1'b0;
    logic                           o_s_axis_tready;
    logic [31:0]                    i_s_axis_tdata = '0;   // src_row, src_col, pixel_in
    logic [ycrm_pkg::PLANE_W-1:0]   i_s_axis_tuser = '0;   // src_plane
    logic                           o_m_axis_tvalid;
    logic                           i_m_axis_tready = 1'b0;
    logic [31:0]                    o_m_axis_tdata;        // dst_offset, pixel_out
    logic [ycrm_pkg::PLANE_W-1:0]   o_m_axis_tuser;        // dst_plane

    // Shadow copy of the frame geometry registers.
    logic [ycrm_pkg::DIM_W-1:0] geo_src_w = ycrm_pkg::RST_SRC_WIDTH;
    logic [ycrm_pkg::DIM_W-1:0] geo_src_h = ycrm_pkg::RST_SRC_HEIGHT;
    logic [ycrm_pkg::DIM_W-1:0] geo_crop_w = ycrm_pkg::RST_CROP_WIDTH;
    logic [ycrm_pkg::DIM_W-1:0] geo_crop_h = ycrm_pkg::RST_CROP_HEIGHT;
    ycrm_pkg::t_mode            geo_mode = ycrm_pkg::MODE_CROP;

    // Expected requests in order, as a ring with wrap-aware pointers.
    t_dst_addr            exp_mem [EXP_DEPTH];
    logic [EXP_IDX_W:0]   exp_wr_ptr = '0;
    logic [EXP_IDX_W:0]   exp_rd_ptr = '0;
    t_vec                 dir_tbl[$];
    int                   err_count = 0;
    int                   quiet_cycles = 0;
    bit                   steady = 1'b0;

    yuv420_crop_rotate_mapper DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_addr      (i_cfg_addr),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // Maps a source pixel to its destination plane and offset under the current
    // geometry. Returns 0 when it falls outside the window, has plane code 3 or mode is 3.
    function automatic bit map_pixel(input logic [ycrm_pkg::PLANE_W-1:0] plane,
                                     input logic [ycrm_pkg::ROW_W-1:0] row,
                                     input logic [ycrm_pkg::ROW_W-1:0] col,
                                     output logic [ycrm_pkg::PLANE_W-1:0] dplane,
                                     output logic [ycrm_pkg::OFF_W-1:0] off);
        int unsigned       w, h, cw, ch, ys, xs, r, c;
        longint unsigned   lin;
        dplane = ycrm_pkg::DST_PLANE_Y;
        off = '0;
        if (plane == ycrm_pkg::SRC_PLANE_BAD || geo_mode == ycrm_pkg::MODE_NONE)
            return 1'b0;
        w  = (geo_src_w > DIM_CAP) ? DIM_CAP : geo_src_w;
        h  = (geo_src_h > DIM_CAP) ? DIM_CAP : geo_src_h;
        cw = (geo_crop_w > w) ? w : geo_crop_w;
        ch = (geo_crop_h > h) ? h : geo_crop_h;
        ys = h - ch;
        xs = w - cw;
        // Chroma planes are subsampled by two in both directions.
        if (plane != ycrm_pkg::SRC_PLANE_Y) begin
            w = w >> 1;
            h = h >> 1;
            cw = cw >> 1;
            ch = ch >> 1;
            ys = ys >> 1;
            xs = xs >> 1;
        end
        if (row >= h || col >= w)
            return 1'b0;
        if (geo_mode == ycrm_pkg::MODE_CROP || geo_mode == ycrm_pkg::MODE_ROT90) begin
            // Window keeps the bottom rows and the left columns.
            if (row < ys)
                return 1'b0;
            r = row - ys;
            if (r >= ch || col >= cw)
                return 1'b0;
            if (geo_mode == ycrm_pkg::MODE_CROP)
                lin = longint'(r) * cw + col;
            else
                lin = longint'(col) * ch + (ch - 1 - r);
        end else begin
            // Window keeps the top rows and the right columns.
            if (row >= ch || col < xs)
                return 1'b0;
            c = col - xs;
            if (c >= cw)
                return 1'b0;
            lin = longint'(cw - 1 - c) * ch + (ch - 1 - row);
        end
        // Source chroma order is V, U; destination is U, V.
        if (plane == ycrm_pkg::SRC_PLANE_Y)
            dplane = ycrm_pkg::DST_PLANE_Y;
        else if (plane == ycrm_pkg::SRC_PLANE_V)
            dplane = ycrm_pkg::DST_PLANE_V;
        else
            dplane = ycrm_pkg::DST_PLANE_U;
        off = lin[ycrm_pkg::OFF_W-1:0];
        return 1'b1;
    endfunction

    function automatic t_vec cfg_vec(input ycrm_pkg::t_cfg_idx idx, input int val);
        t_vec v;
        v = '0;
        v.is_cfg = 1'b1;
        v.idx = idx;
        v.val = val[ycrm_pkg::DIM_W-1:0];
        return v;
    endfunction

    function automatic t_vec pix_vec(input logic [ycrm_pkg::PLANE_W-1:0] plane, input int row,
                                     input int col, input int pix);
        t_vec v;
        v = '0;
        v.plane = plane;
        v.row = row[ycrm_pkg::ROW_W-1:0];
        v.col = col[ycrm_pkg::ROW_W-1:0];
        v.pix = pix[ycrm_pkg::PIX_W-1:0];
        return v;
    endfunction

    function automatic t_vec known_vec(input logic [ycrm_pkg::PLANE_W-1:0] plane,
                                       input int row, input int col, input int pix,
                                       input bit hit,
                                       input logic [ycrm_pkg::PLANE_W-1:0] dplane,
                                       input int off);
        t_vec v;
        v = pix_vec(plane, row, col, pix);
        v.typed = 1'b1;
        v.hit = hit;
        v.dplane = dplane;
        v.off = off[ycrm_pkg::OFF_W-1:0];
        return v;
    endfunction

    // Prints one mismatch line and counts it.
    task automatic flag_mismatch(input string what, input longint got, input longint want);
        err_count++;
        $display("ERROR at %0t ns: %s: got %0d, expected %0d", $time, what, got, want);
    endtask

    // Writes one geometry register while the stream is idle. Starts and ends
    // at a falling edge; a trailing wait lets the derived geometry settle.
    task automatic write_reg(input ycrm_pkg::t_cfg_idx idx,
                             input logic [ycrm_pkg::DIM_W-1:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_addr <= idx;
        i_cfg_wdata <= val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        unique case (idx)
            ycrm_pkg::CFG_SRC_WIDTH:   geo_src_w = val;
            ycrm_pkg::CFG_SRC_HEIGHT:  geo_src_h = val;
            ycrm_pkg::CFG_CROP_WIDTH:  geo_crop_w = val;
            ycrm_pkg::CFG_CROP_HEIGHT: geo_crop_h = val;
            ycrm_pkg::CFG_XFORM_MODE:
                geo_mode = ycrm_pkg::t_mode'(val[ycrm_pkg::MODE_W-1:0]);
            default: ;
        endcase
        @(negedge i_clk);
    endtask

    // Drops the source valid and waits until every expected request is back,
    // then lets dropped pixels still in the pipeline run out.
    task automatic wait_drained();
        i_s_axis_tvalid <= 1'b0;
        while (exp_wr_ptr != exp_rd_ptr)
            @(negedge i_clk);
        repeat (DRAIN_TAIL) @(negedge i_clk);
    endtask

    // Offers one pixel, with a random idle gap first outside steady phases, and records what it
    // should produce once it is accepted. Valid stays high on return.
    task automatic send_pixel(input t_vec v);
        t_dst_addr                    exp_addr;
        logic [ycrm_pkg::PLANE_W-1:0] dplane;
        logic [ycrm_pkg::OFF_W-1:0]   off;
        bit                           hit;
        while (!steady && $urandom_range(0, 99) < 33) begin
            i_s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata <= {v.pix, v.col, v.row};
        i_s_axis_tuser <= v.plane;
        do
            @(posedge i_clk);
        while (!o_s_axis_tready);
        if (v.typed) begin
            hit = v.hit;
            dplane = v.dplane;
            off = v.off;
        end else begin
            hit = map_pixel(v.plane, v.row, v.col, dplane, off);
        end
        if (hit) begin
            exp_addr.plane = dplane;
            exp_addr.off = off;
            exp_addr.pix = v.pix;
            if ((exp_wr_ptr - exp_rd_ptr) == (EXP_IDX_W + 1)'(EXP_DEPTH))
                flag_mismatch("expected requests outstanding", EXP_DEPTH + 1, EXP_DEPTH);
            exp_mem[exp_wr_ptr[EXP_IDX_W-1:0]] = exp_addr;
            exp_wr_ptr = exp_wr_ptr + 1'b1;
        end
        @(negedge i_clk);
    endtask

    // Programs one random geometry and streams a batch of pixels through it.
    task automatic run_phase(input int idx);
        logic [ycrm_pkg::DIM_W-1:0]   sw, sh, cw, ch;
        logic [ycrm_pkg::PLANE_W-1:0] pl;
        int unsigned                  pl_w, pl_h;
        int                           row, col, sel;
        ycrm_pkg::t_mode              mode;
        mode = ycrm_pkg::t_mode'(idx % 4);
        if (idx == 4) begin
            // Oversized source and crop, both saturated.
            sw = 13'd8191;
            sh = 13'd8191;
            cw = 13'd8191;
            ch = 13'd8191;
        end else if (idx == 5) begin
            // Smallest legal frame.
            sw = 13'd2;
            sh = 13'd2;
            cw = 13'd2;
            ch = 13'd2;
        end else if (idx == 9) begin
            sw = ycrm_pkg::DIM_W'(DIM_CAP);
            sh = ycrm_pkg::DIM_W'(DIM_CAP);
            cw = ycrm_pkg::DIM_W'(DIM_CAP);
            ch = ycrm_pkg::DIM_W'(DIM_CAP);
        end else begin
            // Small frames; crops may be empty or exceed the source.
            sw = ycrm_pkg::DIM_W'($urandom_range(2, 96));
            sh = ycrm_pkg::DIM_W'($urandom_range(2, 96));
            cw = ycrm_pkg::DIM_W'($urandom_range(0, int'(sw) + 8));
            ch = ycrm_pkg::DIM_W'($urandom_range(0, int'(sh) + 8));
        end
        wait_drained();
        write_reg(ycrm_pkg::CFG_SRC_WIDTH, sw);
        write_reg(ycrm_pkg::CFG_SRC_HEIGHT, sh);
        write_reg(ycrm_pkg::CFG_CROP_WIDTH, cw);
        write_reg(ycrm_pkg::CFG_CROP_HEIGHT, ch);
        write_reg(ycrm_pkg::CFG_XFORM_MODE, ycrm_pkg::DIM_W'(mode));
        steady = (idx == 2 || idx == 6);
        for (int n = 0; n < PHASE_PIXELS; n++) begin
            sel = int'($urandom_range(0, 99));
            if (sel < 75) begin
                // Pixel inside its source plane.
                pl = ycrm_pkg::PLANE_W'($urandom_range(0, 2));
                pl_w = (geo_src_w > DIM_CAP) ? DIM_CAP : geo_src_w;
                pl_h = (geo_src_h > DIM_CAP) ? DIM_CAP : geo_src_h;
                if (pl != ycrm_pkg::SRC_PLANE_Y) begin
                    pl_w = pl_w >> 1;
                    pl_h = pl_h >> 1;
                end
                row = int'($urandom_range(0, pl_h - 1));
                col = int'($urandom_range(0, pl_w - 1));
            end else begin
                // Anything the fields allow, bad plane code included.
                pl = ycrm_pkg::PLANE_W'($urandom_range(0, 3));
                row = int'($urandom_range(0, 4095));
                col = int'($urandom_range(0, 4095));
            end
            send_pixel(pix_vec(pl, row, col, int'($urandom_range(0, 255))));
        end
        steady = 1'b0;
    endtask

    // Destination side back-pressure.
    always @(negedge i_clk)
        i_m_axis_tready <= steady || ($urandom_range(0, 99) >= 33);

    // Compare every destination request with the oldest expectation.
    always @(posedge i_clk) begin
        t_dst_addr want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (exp_wr_ptr == exp_rd_ptr) begin
                flag_mismatch("unexpected request, offset",
                              o_m_axis_tdata[ycrm_pkg::OFF_W-1:0], -1);
            end else begin
                want = exp_mem[exp_rd_ptr[EXP_IDX_W-1:0]];
                exp_rd_ptr = exp_rd_ptr + 1'b1;
                if (o_m_axis_tuser !== want.plane)
                    flag_mismatch("dst_plane", o_m_axis_tuser, want.plane);
                if (o_m_axis_tdata[ycrm_pkg::OFF_W-1:0] !== want.off)
                    flag_mismatch("dst_offset", o_m_axis_tdata[ycrm_pkg::OFF_W-1:0],
                                  want.off);
                if (o_m_axis_tdata[31:ycrm_pkg::OFF_W] !== want.pix)
                    flag_mismatch("pixel_out", o_m_axis_tdata[31:ycrm_pkg::OFF_W], want.pix);
            end
        end
    end

    // Watchdog: ends the run when nothing moves for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || i_cfg_we || (i_s_axis_tvalid && o_s_axis_tready) ||
            (o_m_axis_tvalid && i_m_axis_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("FAIL yuv420_crop_rotate_mapper");
                $finish;
            end
        end
    end

    initial begin
        // Corners, plane swap, drops, saturated sizes, then both rotate modes on a cropped
        // frame whose chroma row start is odd, mode 3, and an empty crop.
        dir_tbl = '{
            known_vec(PY, 0, 0, 8'h00, 1'b1, DY, 0),
            known_vec(PY, 479, 639, 8'hFF, 1'b1, DY, 307199),
            known_vec(PV, 0, 0, 8'hA5, 1'b1, DV, 0),
            known_vec(PU, 239, 319, 8'h5A, 1'b1, DU, 76799),
            known_vec(PY, 480, 0, 8'h11, 1'b0, DY, 0),
            known_vec(PY, 0, 640, 8'h22, 1'b0, DY, 0),
            known_vec(PBAD, 0, 0, 8'h33, 1'b0, DY, 0),
            known_vec(PY, 4095, 4095, 8'h44, 1'b0, DY, 0),
            known_vec(PV, 240, 0, 8'h55, 1'b0, DY, 0),
            cfg_vec(ycrm_pkg::CFG_SRC_WIDTH, 8191),
            cfg_vec(ycrm_pkg::CFG_SRC_HEIGHT, 8191),
            cfg_vec(ycrm_pkg::CFG_CROP_WIDTH, 4096),
            cfg_vec(ycrm_pkg::CFG_CROP_HEIGHT, 4096),
            known_vec(PY, 4095, 4095, 8'h81, 1'b1, DY, 16777215),
            known_vec(PU, 2047, 2047, 8'h3C, 1'b1, DU, 4194303),
            known_vec(PY, 0, 0, 8'h7E, 1'b1, DY, 0),
            cfg_vec(ycrm_pkg::CFG_SRC_WIDTH, 64),
            cfg_vec(ycrm_pkg::CFG_SRC_HEIGHT, 48),
            cfg_vec(ycrm_pkg::CFG_CROP_WIDTH, 40),
            cfg_vec(ycrm_pkg::CFG_CROP_HEIGHT, 30),
            cfg_vec(ycrm_pkg::CFG_XFORM_MODE, int'(ycrm_pkg::MODE_ROT90)),
            pix_vec(PY, 18, 0, 8'h01),
            pix_vec(PY, 47, 39, 8'h02),
            pix_vec(PY, 17, 0, 8'h03),
            pix_vec(PV, 9, 0, 8'h04),
            pix_vec(PU, 23, 19, 8'h05),
            pix_vec(PU, 24, 0, 8'h06),
            cfg_vec(ycrm_pkg::CFG_XFORM_MODE, int'(ycrm_pkg::MODE_ROT270_MIR)),
            pix_vec(PY, 0, 24, 8'h07),
            pix_vec(PY, 29, 63, 8'h08),
            pix_vec(PY, 30, 24, 8'h09),
            pix_vec(PY, 0, 23, 8'h0A),
            pix_vec(PV, 14, 12, 8'h0B),
            cfg_vec(ycrm_pkg::CFG_XFORM_MODE, int'(ycrm_pkg::MODE_NONE)),
            known_vec(PY, 0, 24, 8'h0C, 1'b0, DY, 0),
            cfg_vec(ycrm_pkg::CFG_XFORM_MODE, int'(ycrm_pkg::MODE_CROP)),
            cfg_vec(ycrm_pkg::CFG_CROP_WIDTH, 0),
            known_vec(PY, 18, 0, 8'h0D, 1'b0, DY, 0)
        };

        repeat (RST_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed table.
        foreach (dir_tbl[k]) begin
            if (dir_tbl[k].is_cfg) begin
                wait_drained();
                write_reg(dir_tbl[k].idx, dir_tbl[k].val);
            end else begin
                send_pixel(dir_tbl[k]);
            end
        end

        // Random phases.
        for (int p = 0; p < NUM_PHASES; p++)
            run_phase(p);

        wait_drained();
        if (err_count == 0)
            $display("PASS yuv420_crop_rotate_mapper");
        else
            $display("FAIL yuv420_crop_rotate_mapper");
        $finish;
    end

endmodule
